// ===== rtl/core/cpbd_pkg.sv =====
// Package with the shared types, constants and the helper function of the cassette decoder.
`timescale 1ns / 1ps
`default_nettype none

package cpbd_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_VTAPE_EN  = 2'd0;
  localparam logic [1:0] REG_OVERRUN   = 2'd1;
  localparam logic [1:0] REG_ONE_LIMIT = 2'd2;
  localparam logic [1:0] REG_SYNC      = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic        VTAPE_EN_RST  = 1'b1;
  localparam logic [15:0] OVERRUN_RST   = 16'd4000;
  localparam logic [15:0] ONE_LIMIT_RST = 16'd2000;
  localparam logic [15:0] SYNC_RST      = 16'hcc33;

  // Tape levels that carry a meaning of their own
  localparam logic [1:0] LEVEL_LOW  = 2'd0;
  localparam logic [1:0] LEVEL_RISE = 2'd1;
  localparam logic [1:0] LEVEL_HIGH = 2'd2;

  // DAC output levels
  localparam logic [7:0] DAC_IDLE = 8'd117;
  localparam logic [7:0] DAC_HIGH = 8'd217;
  localparam logic [7:0] DAC_ZERO = 8'd0;

  // Bits in one framed byte (clock and data bits interleaved)
  localparam logic [4:0] BITS_PER_FRAME = 5'd16;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_DAC   = 2'd2
  } cpbd_kind_e;

  typedef struct packed {
    logic        vtape_en;
    logic [15:0] overrun_limit;
    logic [15:0] one_bit_limit;
    logic [15:0] sync_pattern;
  } cpbd_cfg_t;

  typedef struct packed {
    logic [1:0]  last_level;
    logic [31:0] last_time;
    logic [15:0] shift_reg;
    logic [4:0]  bits;
    logic        sync;
  } cpbd_state_t;

  typedef struct packed {
    logic       valid;
    cpbd_kind_e kind;
    logic [7:0] value;
  } cpbd_result_t;

  // Pick the data bits at the odd positions 15, 13, ..., 1 into byte bits 7..0.
  function automatic logic [7:0] odd_bits_byte(input logic [15:0] sr);
    logic [7:0] v;
    v = '0;
    for (int k = 0; k < 8; k++) begin
      v[k] = sr[2*k+1];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cpbd_in_if.sv =====
// Input channel interface: tape level writes with their timestamps.
`timescale 1ns / 1ps
`default_nettype none

interface cpbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tape_level;
  logic [31:0] timestamp;

  modport source (output valid, output tape_level, output timestamp, input ready);
  modport sink   (input valid, input tape_level, input timestamp, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cpbd_out_if.sv =====
// Output channel interface: decoded bytes, flushed bytes and DAC levels.
`timescale 1ns / 1ps
`default_nettype none

interface cpbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] result_value;

  modport source (output valid, output result_kind, output result_value, input ready);
  modport sink   (input valid, input result_kind, input result_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cpbd_cfg_regs.sv =====
// Configuration register file of the cassette decoder.
`timescale 1ns / 1ps
`default_nettype none

module cpbd_cfg_regs
  import cpbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cpbd_cfg_t                  cfg_o
);

  cpbd_cfg_t cfg_q, cfg_d;

  // Decode the register index of a write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VTAPE_EN:  cfg_d.vtape_en      = cfg_wdata_i[0];
        REG_OVERRUN:   cfg_d.overrun_limit = cfg_wdata_i;
        REG_ONE_LIMIT: cfg_d.one_bit_limit = cfg_wdata_i;
        REG_SYNC:      cfg_d.sync_pattern  = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vtape_en      <= VTAPE_EN_RST;
      cfg_q.overrun_limit <= OVERRUN_RST;
      cfg_q.one_bit_limit <= ONE_LIMIT_RST;
      cfg_q.sync_pattern  <= SYNC_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/cpbd_step.sv =====
// Decode logic for one level write: next decoder state and the optional result.
`timescale 1ns / 1ps
`default_nettype none

module cpbd_step
  import cpbd_pkg::*;
(
  input  wire cpbd_cfg_t    cfg_i,
  input  wire cpbd_state_t  state_i,
  input  wire logic [1:0]   level_i,
  input  wire logic [31:0]  ts_i,
  output cpbd_state_t       state_o,
  output cpbd_result_t      result_o
);

  logic [31:0] gap;
  logic        overrun;
  logic        short_gap;
  logic [4:0]  pad_shift;
  logic [15:0] padded;
  logic [15:0] sr_next;
  logic [4:0]  bits_next;
  logic        sync_next;

  // Interval since the last acted write, modulo 2^32.
  assign gap       = ts_i - state_i.last_time;
  assign overrun   = gap > {16'd0, cfg_i.overrun_limit};
  assign short_gap = gap < {16'd0, cfg_i.one_bit_limit};

  // A partial byte is padded with zeros at the low end before the flush.
  assign pad_shift = BITS_PER_FRAME - state_i.bits;
  assign padded    = state_i.shift_reg << pad_shift;

  // Shift in one 1 bit on a short pulse, two 0 bits on a long one.
  always_comb begin
    sr_next   = state_i.shift_reg;
    bits_next = state_i.bits;
    sync_next = state_i.sync;
    if (short_gap) begin
      sr_next = {state_i.shift_reg[14:0], 1'b1};
      if (state_i.sync) begin
        bits_next = state_i.bits + 5'd1;
      end else if (sr_next == cfg_i.sync_pattern) begin
        sync_next = 1'b1;
        bits_next = BITS_PER_FRAME;
      end
    end else begin
      sr_next = {state_i.shift_reg[13:0], 2'b00};
      if (state_i.sync) begin
        bits_next = state_i.bits + 5'd2;
      end
    end
  end

  // Select the action for this write.
  always_comb begin
    state_o        = state_i;
    result_o.valid = 1'b0;
    result_o.kind  = KIND_BYTE;
    result_o.value = '0;
    if (level_i != state_i.last_level) begin
      state_o.last_level = level_i;
      if (cfg_i.vtape_en) begin
        state_o.last_time = ts_i;
        if (overrun) begin
          if (state_i.bits != 5'd0 && state_i.bits < BITS_PER_FRAME) begin
            result_o.valid = 1'b1;
            result_o.kind  = KIND_FLUSH;
            result_o.value = odd_bits_byte(padded);
          end
          state_o.shift_reg = '0;
          state_o.bits      = '0;
          state_o.sync      = 1'b0;
        end else if (level_i == LEVEL_RISE) begin
          state_o.shift_reg = sr_next;
          state_o.bits      = bits_next;
          state_o.sync      = sync_next;
          if (bits_next >= BITS_PER_FRAME) begin
            result_o.valid    = 1'b1;
            result_o.kind     = KIND_BYTE;
            result_o.value    = odd_bits_byte(sr_next);
            state_o.bits      = bits_next - BITS_PER_FRAME;
            state_o.shift_reg = '0;
          end
        end
      end else begin
        result_o.valid = 1'b1;
        result_o.kind  = KIND_DAC;
        case (level_i)
          LEVEL_LOW:  result_o.value = DAC_IDLE;
          LEVEL_HIGH: result_o.value = DAC_HIGH;
          default:    result_o.value = DAC_ZERO;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cassette_pulse_bit_decoder_top.sv =====
// Top level of the cassette pulse-interval bit decoder with DAC pass-through.
//
//   Channel   Direction  Payload                           Handshake
//   in_i      sink       tape_level[1:0], timestamp[31:0]  valid/ready
//   out_o     source     result_kind[1:0], result_value    valid/ready
//   cfg       write      cfg_idx_i[1:0], cfg_wdata_i[15:0] cfg_we_i
//
// One write is taken per cycle while the output does not stall; it is held in the input
// register and its result is then loaded into the output register for the sink to take.
// The decoder state is updated in the same cycle, so back-to-back writes chain at full rate.
// Reset (rst_ni low, asynchronous) restores the register defaults and clears the decoder.
// A stalled output holds the input register; a new write is taken whenever that register
// is empty or moves on in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module cassette_pulse_bit_decoder_top
  import cpbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  cpbd_in_if.sink                    in_i,
  cpbd_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cpbd_cfg_t    cfg;
  cpbd_state_t  state_q, state_d;
  cpbd_result_t result;

  logic        in_valid_q;
  logic [1:0]  level_q;
  logic [31:0] ts_q;
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  value_q;
  logic        out_free;
  logic        fire;

  cpbd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cpbd_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .level_i  (level_q),
    .ts_i     (ts_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // The held write completes when the output register can take its result.
  assign out_free   = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      level_q <= in_i.tape_level;
      ts_q    <= in_i.timestamp;
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && result.valid) begin
      kind_q  <= result.kind;
      value_q <= result.value;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = kind_q;
  assign out_o.result_value = value_q;

  // A new result only follows a completed write.
  a_result_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire))
    else $error("result appeared without a completed write");

  // A pending partial byte never reaches a full frame between writes.
  a_bits_below_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bits < BITS_PER_FRAME)
    else $error("bit count left at a full frame");

  // Bits are only counted after sync was found.
  a_bits_need_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.sync |-> state_q.bits == 5'd0)
    else $error("bits counted without sync");

  // A write of the unchanged level leaves the decoder untouched.
  a_same_level_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && level_q == state_q.last_level |=> $stable(state_q))
    else $error("unchanged level altered the decoder state");

endmodule

`default_nettype wire
